// ===== src/assert_macros.svh =====
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`endif
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== src/cna_pkg.sv =====
// Package: types, constants and tables of the complex number ALU
`default_nettype none
package cna_pkg;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int FRAC_BITS_DEF     = 8;
    localparam int MAX_STAGES        = 24;
    localparam int RES_W             = 33;
    localparam logic [31:0] INV_GAIN_Q32 = 32'd2608131496;
    localparam logic [31:0] ANGLE_PI     = 32'h8000_0000;

    typedef enum logic [1:0] {
        FUNC_ADD = 2'd0,
        FUNC_MUL = 2'd1,
        FUNC_MOD = 2'd2,
        FUNC_ARG = 2'd3
    } t_func;

    typedef struct packed {
        logic              valid;
        t_func             func;
        logic              zero;
        logic signed [32:0] re;
        logic signed [32:0] im;
    } t_ctl;

    function automatic logic [31:0] atan_tab(input int idx);
        logic [31:0] v;
        case (idx)
            0: v = 32'd536870912;  1: v = 32'd316933406;
            2: v = 32'd167458907;  3: v = 32'd85004756;
            4: v = 32'd42667331;   5: v = 32'd21354465;
            6: v = 32'd10679838;   7: v = 32'd5340245;
            8: v = 32'd2670163;    9: v = 32'd1335087;
            10: v = 32'd667544;    11: v = 32'd333772;
            12: v = 32'd166886;    13: v = 32'd83443;
            14: v = 32'd41722;     15: v = 32'd20861;
            16: v = 32'd10430;     17: v = 32'd5215;
            18: v = 32'd2608;      19: v = 32'd1304;
            20: v = 32'd652;       21: v = 32'd326;
            22: v = 32'd163;       23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

// ===== src/cna_cell.sv =====
// One CORDIC vectoring cell with its item control, registered
`default_nettype none
module cna_cell #(
    parameter int IDX = 0,
    parameter int XW  = 28
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_en,
    input  wire cna_pkg::t_ctl       i_ctl,
    input  wire logic signed [XW-1:0] i_x,
    input  wire logic signed [XW-1:0] i_y,
    input  wire logic [31:0]         i_z,
    output cna_pkg::t_ctl            o_ctl,
    output logic signed [XW-1:0]     o_x,
    output logic signed [XW-1:0]     o_y,
    output logic [31:0]              o_z
);
    import cna_pkg::*;
    localparam logic [31:0] T = atan_tab(IDX);
    t_ctl r_ctl;
    logic signed [XW-1:0] r_x, r_y, n_x, n_y;
    logic [31:0] r_z, n_z;

    always_comb begin
        if (!i_y[XW-1]) begin
            n_x = i_x + (i_y >>> IDX);
            n_y = i_y - (i_x >>> IDX);
            n_z = i_z + T;
        end else begin
            n_x = i_x - (i_y >>> IDX);
            n_y = i_y + (i_x >>> IDX);
            n_z = i_z - T;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl.valid <= i_ctl.valid;
        end
        if (i_en) begin
            r_ctl.func <= i_ctl.func;
            r_ctl.zero <= i_ctl.zero;
            r_ctl.re   <= i_ctl.re;
            r_ctl.im   <= i_ctl.im;
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end
    assign o_ctl = r_ctl;
    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;
endmodule
`default_nettype wire

// ===== src/complex_number_alu_top.sv =====
// Top level of the complex number ALU: entry stage, CORDIC cell chain, output stage
// Fully pipelined: one item per cycle while the chain is not held. Stages: entry
// register with the add and the four partial products, CORDIC_STAGES vectoring
// cells, gain multiply register, output register. Add and multiply results ride
// alongside. The whole chain advances when the output register is empty or is
// being taken; i_stall holds every stage only while the output register is full.
`default_nettype none
`include "assert_macros.svh"
module complex_number_alu_top #(
    parameter int CORDIC_STAGES = cna_pkg::CORDIC_STAGES_DEF,
    parameter int FRAC_BITS     = cna_pkg::FRAC_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [1:0]         i_func,
    input  wire logic signed [15:0] i_a_re,
    input  wire logic signed [15:0] i_a_im,
    input  wire logic signed [15:0] i_b_re,
    input  wire logic signed [15:0] i_b_im,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [32:0]      o_res_re,
    output logic signed [32:0]      o_res_im,
    output logic                    o_status
);
    import cna_pkg::*;
    localparam int XW = 16 + FRAC_BITS + 4;
    localparam int MW = XW + 32;

    logic en;
    t_ctl ctl [CORDIC_STAGES+1];
    logic signed [XW-1:0] xs [CORDIC_STAGES+1];
    logic signed [XW-1:0] ys [CORDIC_STAGES+1];
    logic [31:0] zs [CORDIC_STAGES+1];

    t_ctl r_e;
    logic signed [XW-1:0] r_ex, r_ey;
    logic [31:0] r_ez;
    logic signed [31:0] r_p0, r_p1, r_p2, r_p3;
    logic signed [XW-1:0] n_x, n_y, ax, ay;
    t_ctl n_e;

    t_ctl r_m;
    logic [MW-1:0] r_mag;
    logic [31:0] r_mz;

    logic r_ov;
    logic signed [32:0] r_re, r_im;
    logic r_st;

    assign en = !r_ov || !i_stall;
    assign o_stall = !en;

    always_comb begin
        ax = XW'(i_a_re) <<< FRAC_BITS;
        ay = XW'(i_a_im) <<< FRAC_BITS;
        n_e.valid = i_valid;
        n_e.func = t_func'(i_func);
        n_e.zero = (i_a_re == 16'sd0) && (i_a_im == 16'sd0);
        n_e.re = 33'(i_a_re) + 33'(i_b_re);
        n_e.im = 33'(i_a_im) + 33'(i_b_im);
        if (i_a_re < 0) begin
            n_x = -ax;
            n_y = -ay;
        end else begin
            n_x = ax;
            n_y = ay;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e.valid <= 1'b0;
        end else if (en) begin
            r_e.valid <= n_e.valid;
        end
        if (en) begin
            r_e.func <= n_e.func;
            r_e.zero <= n_e.zero;
            r_e.re <= n_e.re;
            r_e.im <= n_e.im;
            r_ex <= n_x;
            r_ey <= n_y;
            r_ez <= (i_a_re < 0) ? ANGLE_PI : 32'd0;
            r_p0 <= i_a_re * i_b_re;
            r_p1 <= i_a_im * i_b_im;
            r_p2 <= i_a_re * i_b_im;
            r_p3 <= i_a_im * i_b_re;
        end
    end

    always_comb begin
        ctl[0] = r_e;
        if (r_e.func == FUNC_MUL) begin
            ctl[0].re = 33'(r_p0) - 33'(r_p1);
            ctl[0].im = 33'(r_p2) + 33'(r_p3);
        end
    end
    assign xs[0] = r_ex;
    assign ys[0] = r_ey;
    assign zs[0] = r_ez;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        cna_cell #(.IDX(g), .XW(XW)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_ctl(ctl[g]), .i_x(xs[g]), .i_y(ys[g]), .i_z(zs[g]),
            .o_ctl(ctl[g+1]), .o_x(xs[g+1]), .o_y(ys[g+1]), .o_z(zs[g+1])
        );
    end

    logic [XW-1:0] xc;
    assign xc = xs[CORDIC_STAGES][XW-1] ? '0 : xs[CORDIC_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m.valid <= 1'b0;
        end else if (en) begin
            r_m.valid <= ctl[CORDIC_STAGES].valid;
        end
        if (en) begin
            r_m.func <= ctl[CORDIC_STAGES].func;
            r_m.zero <= ctl[CORDIC_STAGES].zero;
            r_m.re <= ctl[CORDIC_STAGES].re;
            r_m.im <= ctl[CORDIC_STAGES].im;
            r_mag <= MW'(xc) * MW'(INV_GAIN_Q32);
            r_mz <= zs[CORDIC_STAGES];
        end
    end

    logic [MW-1:0] mag_r;
    logic [31:0] zr;
    logic signed [32:0] ang, mag;
    logic signed [32:0] n_re, n_im;
    logic n_st;
    always_comb begin
        mag_r = r_mag + (MW'(1) << (31 + FRAC_BITS));
        mag = 33'(mag_r >> (32 + FRAC_BITS));
        zr = r_mz + 32'h0000_8000;
        ang = 33'(signed'(zr[31:16]));
        if (zr[31:16] == 16'h8000) begin
            ang = 33'sd32768;
        end
        n_re = r_m.re;
        n_im = r_m.im;
        n_st = 1'b0;
        unique case (r_m.func) inside
            FUNC_ADD, FUNC_MUL: begin
            end
            FUNC_MOD: begin
                n_im = '0;
                n_re = r_m.zero ? '0 : mag;
            end
            FUNC_ARG: begin
                n_im = '0;
                n_re = r_m.zero ? '0 : ang;
                n_st = r_m.zero;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_m.valid;
        end
        if (en) begin
            r_re <= n_re;
            r_im <= n_im;
            r_st <= n_st;
        end
    end

    assign o_valid = r_ov;
    assign o_res_re = r_re;
    assign o_res_im = r_im;
    assign o_status = r_st;

    `ASSERT_CLK(a_hold, i_clk, i_rst_n, (r_ov && i_stall) |=> (r_ov && $stable(r_re)))
    `ASSERT_CLK(a_stall, i_clk, i_rst_n, o_stall == (r_ov && i_stall))
    `ASSERT_CLK(a_st, i_clk, i_rst_n, (r_ov && r_st) |-> (r_re == 33'sd0 && r_im == 33'sd0))
endmodule
`default_nettype wire
